/* hw/rtl/pcrc_pkg.sv */
package pcrc_pkg;

  localparam int unsigned CrcWidth  = 32;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned StatWidth = 3;

  localparam logic [CrcWidth-1:0] CrcPoly    = 32'hEDB8_8320;
  localparam logic [CrcWidth-1:0] CrcAllOnes = 32'hFFFF_FFFF;
  localparam logic [CrcWidth-1:0] MarkNormal = 32'hFFFF_FFFF;
  localparam logic [CrcWidth-1:0] MarkBitmap = 32'hFFFF_FFFE;
  localparam logic [CrcWidth-1:0] CrcClamp   = 32'hFFFF_FFFD;

  localparam logic OpCompute = 1'b0;
  localparam logic OpCheck   = 1'b1;

  localparam logic KindNormal = 1'b0;
  localparam logic KindBitmap = 1'b1;

  typedef enum logic [StatWidth-1:0] {
    STAT_MATCH        = 3'd0,
    STAT_MARKER_OK    = 3'd1,
    STAT_BLANK_BITMAP = 3'd2,
    STAT_MISMATCH     = 3'd3,
    STAT_BAD_MARKER   = 3'd4
  } status_t;

  typedef struct packed {
    logic                 operation;
    logic                 page_kind;
    logic [CrcWidth-1:0]  page_number;
    logic [ByteWidth-1:0] data_byte;
    logic                 first_byte;
    logic                 last_byte;
    logic [CrcWidth-1:0]  stored_crc;
  } item_t;

  function automatic logic [CrcWidth-1:0] crc_fold(input logic [CrcWidth-1:0]  crc_in,
                                                   input logic [ByteWidth-1:0] data);
    logic [CrcWidth-1:0] r;
    r = crc_in ^ {{(CrcWidth-ByteWidth){1'b0}}, data};
    for (int i = 0; i < ByteWidth; i++) begin
      r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    end
    return r;
  endfunction

endpackage

/* hw/rtl/pcrc_engine.sv */
module pcrc_engine (
  input  logic                          clk,
  input  logic                          rst,
  input  pcrc_pkg::item_t               item,
  input  logic                          advance,
  output logic [pcrc_pkg::CrcWidth-1:0] crc_value,
  output pcrc_pkg::status_t             status
);
  import pcrc_pkg::*;

  logic [CrcWidth-1:0] running_crc;
  logic                all_zero;
  logic [CrcWidth-1:0] running_crc_next;
  logic                all_zero_next;
  logic [CrcWidth-1:0] base;
  logic [CrcWidth-1:0] final_crc;
  logic [CrcWidth-1:0] marker;

  always_comb begin
    base             = item.first_byte ? ~item.page_number : running_crc;
    running_crc_next = crc_fold(base, item.data_byte);
    all_zero_next    = (item.first_byte | all_zero) & (item.data_byte == '0);
    final_crc        = running_crc_next ^ CrcAllOnes;
    crc_value        = (final_crc >= MarkBitmap) ? CrcClamp : final_crc;
    marker           = (item.page_kind == KindBitmap) ? MarkBitmap : MarkNormal;
    status           = STAT_MATCH;
    if (item.operation == OpCheck) begin
      if (item.stored_crc >= MarkBitmap) begin
        status = (item.stored_crc == marker) ? STAT_MARKER_OK : STAT_BAD_MARKER;
      end else if (crc_value != item.stored_crc) begin
        if (item.page_kind == KindBitmap && item.stored_crc == '0 && all_zero_next) begin
          status = STAT_BLANK_BITMAP;
        end else begin
          status = STAT_MISMATCH;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= '0;
      all_zero    <= 1'b1;
    end else if (advance) begin
      running_crc <= running_crc_next;
      all_zero    <= all_zero_next;
    end
  end

endmodule

/* hw/rtl/page_crc_seal_and_check_unit.sv */
// Page CRC seal and check unit.
// Input stream: one covered page byte per request. tuser flags the operation
// (compute or check), the page kind and the first byte of a page; tlast marks
// the last covered byte, which must carry the stored trailer word in tdata.
// Output stream: one result per page, the clamped CRC in tdata and the status
// code in tuser. Non-last bytes produce no output.
// Throughput: one byte per cycle while no last byte waits on a held result,
// set by the byte-wide CRC fold between the input and result registers.
// A last byte goes from the input register, through the fold, to the result register.
// Reset clears both valid flags, sets the running CRC to zero and the
// all-zero flag to one. When the receiver stalls, the result register holds;
// non-last bytes keep flowing, and a further last byte waits in the input
// register until the result is taken, which drops s_axis_tready.
module page_crc_seal_and_check_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // page_number[31:0], data_byte[39:32], stored_crc[71:40]
  input  logic [71:0] s_axis_tdata,
  // operation[0], page_kind[1], first_byte[2]
  input  logic [2:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // crc_value[31:0]
  output logic [31:0] m_axis_tdata,
  // status[2:0]
  output logic [2:0]  m_axis_tuser
);
  import pcrc_pkg::*;

  item_t               stage;
  logic                stage_valid;
  logic                out_free;
  logic                advance;
  logic [CrcWidth-1:0] crc_calc;
  status_t             status_calc;
  item_t               in_item;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = stage_valid && (!stage.last_byte || out_free);
  assign s_axis_tready = !stage_valid || advance;

  always_comb begin
    in_item.page_number = s_axis_tdata[31:0];
    in_item.data_byte   = s_axis_tdata[39:32];
    in_item.stored_crc  = s_axis_tdata[71:40];
    in_item.operation   = s_axis_tuser[0];
    in_item.page_kind   = s_axis_tuser[1];
    in_item.first_byte  = s_axis_tuser[2];
    in_item.last_byte   = s_axis_tlast;
  end

  pcrc_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .item      (stage),
    .advance   (advance),
    .crc_value (crc_calc),
    .status    (status_calc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid   <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        stage_valid <= s_axis_tvalid;
      end
      if (advance && stage.last_byte) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      stage <= in_item;
    end
    if (advance && stage.last_byte) begin
      m_axis_tdata <= crc_calc;
      m_axis_tuser <= status_calc;
    end
  end

  a_no_marker_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata <= CrcClamp))
    else $error("marker value on result");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser <= STAT_BAD_MARKER))
    else $error("status code out of range");

  a_bytes_flow: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !stage.last_byte) |-> advance)
    else $error("non-last byte stalled");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !(advance && stage.last_byte))
    else $error("result overwritten while stalled");

endmodule

/* sim/tb_page_crc_seal_and_check_unit.sv */
`timescale 1ns / 1ps

module tb_page_crc_seal_and_check_unit;
  import pcrc_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int HoldCycles = 240;
  localparam int PhaseItems = 105;

  typedef enum int {
    STORE_MATCH,
    STORE_RANDOM,
    STORE_MARK_NORMAL,
    STORE_MARK_BITMAP,
    STORE_ZERO,
    STORE_NEAR
  } trailer_sel_t;

  class page_crc_scoreboard;
    logic [CrcWidth-1:0] crc_reg;
    bit                  zero_run;
    logic [CrcWidth-1:0] want_crc[$];
    status_t             want_status[$];
    int                  errors;

    function new();
      crc_reg  = '0;
      zero_run = 1'b1;
      errors   = 0;
    endfunction

    function logic [CrcWidth-1:0] fold8(logic [CrcWidth-1:0] r, logic [ByteWidth-1:0] b);
      logic [CrcWidth-1:0] x;
      x = r ^ {24'd0, b};
      repeat (ByteWidth) x = x[0] ? ((x >> 1) ^ CrcPoly) : (x >> 1);
      return x;
    endfunction

    // clamped CRC the page would end with if this byte closes it
    function logic [CrcWidth-1:0] seal_value(logic [CrcWidth-1:0] pno, logic [ByteWidth-1:0] b,
                                             bit is_first);
      logic [CrcWidth-1:0] crc;
      crc = ~fold8(is_first ? ~pno : crc_reg, b);
      if (crc >= MarkBitmap) crc = CrcClamp;
      return crc;
    endfunction

    function void note_request(logic op, logic kind, logic [CrcWidth-1:0] pno,
                               logic [ByteWidth-1:0] b, logic is_first, logic is_last,
                               logic [CrcWidth-1:0] stored);
      logic [CrcWidth-1:0] crc;
      logic [CrcWidth-1:0] marker;
      status_t             st;
      if (is_first) begin
        crc_reg  = ~pno;
        zero_run = 1'b1;
      end
      crc_reg = fold8(crc_reg, b);
      if (b != 8'd0) zero_run = 1'b0;
      if (!is_last) return;
      crc = ~crc_reg;
      if (crc >= MarkBitmap) crc = CrcClamp;
      st = STAT_MATCH;
      if (op == OpCheck) begin
        marker = (kind == KindBitmap) ? MarkBitmap : MarkNormal;
        if (stored >= MarkBitmap) begin
          st = (stored == marker) ? STAT_MARKER_OK : STAT_BAD_MARKER;
        end else if (crc != stored) begin
          if (kind == KindBitmap && stored == '0 && zero_run) st = STAT_BLANK_BITMAP;
          else st = STAT_MISMATCH;
        end
      end
      want_crc.push_back(crc);
      want_status.push_back(st);
    endfunction

    function void check_result(logic [CrcWidth-1:0] crc, logic [StatWidth-1:0] st);
      logic [CrcWidth-1:0] exp_crc;
      status_t             exp_st;
      if (want_crc.size() == 0) begin
        errors++;
        $display("%0t: unexpected result crc_value %h status %0d", $time, crc, st);
        return;
      end
      exp_crc = want_crc.pop_front();
      exp_st  = want_status.pop_front();
      if (crc !== exp_crc) begin
        errors++;
        $display("%0t: crc_value expected %h actual %h", $time, exp_crc, crc);
      end
      if (st !== exp_st) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, exp_st, st);
      end
    endfunction

    function int pending();
      return want_crc.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  page_crc_scoreboard sb;
  int tx_idle_pct;
  int rx_stall_pct;
  bit rx_hold_req;
  int items_sent;
  int quiet_cycles;

  page_crc_seal_and_check_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_request(s_axis_tuser[0], s_axis_tuser[1], s_axis_tdata[31:0],
                        s_axis_tdata[39:32], s_axis_tuser[2], s_axis_tlast,
                        s_axis_tdata[71:40]);
      end
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no progress for %0d cycles", $time, QuietLimit);
        $display("page_crc_seal_and_check_unit verification failed");
        $finish;
      end
    end
  end

  // result side: random stalls, or one long hold when asked
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        rx_hold_req = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  function automatic logic [CrcWidth-1:0] seed_for_crc(input logic [CrcWidth-1:0] target);
    logic [CrcWidth-1:0] r;
    r = ~target;
    repeat (ByteWidth) r = r[31] ? (((r ^ CrcPoly) << 1) | 32'd1) : (r << 1);
    return ~r;
  endfunction

  // enter and leave on a falling edge; valid stays high for the caller
  task automatic send_byte(logic op, logic kind, logic [31:0] pno, logic [7:0] b,
                           logic is_first, logic is_last, logic [31:0] stored);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {stored, b, pno};
    s_axis_tuser  <= {is_first, kind, op};
    s_axis_tlast  <= is_last;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_page(int len, logic op, logic kind, logic [31:0] pno, bit with_first,
                           trailer_sel_t sel, int fill, bit closed);
    logic [31:0] pn;
    logic [31:0] stored;
    logic [7:0]  b;
    bit          is_first;
    bit          is_last;
    for (int i = 0; i < len; i++) begin
      b        = (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
      is_first = with_first && (i == 0);
      is_last  = closed && (i == len - 1);
      pn       = is_first ? pno : $urandom;
      stored   = $urandom;
      if (is_last) begin
        case (sel)
          STORE_MATCH:       stored = sb.seal_value(pn, b, is_first);
          STORE_MARK_NORMAL: stored = MarkNormal;
          STORE_MARK_BITMAP: stored = MarkBitmap;
          STORE_ZERO:        stored = '0;
          STORE_NEAR:        stored = sb.seal_value(pn, b, is_first) ^
                                      (32'd1 << $urandom_range(31));
          default:           stored = $urandom;
        endcase
        send_byte(op, kind, pn, b, is_first, is_last, stored);
      end else begin
        send_byte(1'($urandom_range(1)), 1'($urandom_range(1)), pn, b, is_first, is_last,
                  stored);
      end
    end
  endtask

  task automatic random_page();
    int           r;
    int           len;
    int           fill;
    trailer_sel_t sel;
    r   = $urandom_range(99);
    len = (r < 80) ? $urandom_range(8, 1) : ((r < 95) ? $urandom_range(24, 9) : 1);
    r   = $urandom_range(99);
    if (r < 35) sel = STORE_MATCH;
    else if (r < 55) sel = STORE_RANDOM;
    else if (r < 63) sel = STORE_MARK_NORMAL;
    else if (r < 71) sel = STORE_MARK_BITMAP;
    else if (r < 85) sel = STORE_ZERO;
    else sel = STORE_NEAR;
    fill = -1;
    if (sel == STORE_ZERO && $urandom_range(1) == 1) fill = 0;
    else if ($urandom_range(19) == 0) fill = ($urandom_range(1) == 1) ? 0 : 255;
    send_page(len, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom,
              $urandom_range(99) >= 8, sel, fill, $urandom_range(99) >= 4);
  endtask

  // hold input until every result is back, then let the pipe settle
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int target;
    sb            = new();
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tlast  = 1'b0;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    rx_hold_req   = 1'b0;
    items_sent    = 0;
    quiet_cycles  = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // continue from reset state without a first byte
    send_page(1, OpCheck, KindNormal, $urandom, 0, STORE_MATCH, -1, 1);
    send_page(1, OpCompute, KindNormal, 32'h0000_0000, 1, STORE_ZERO, 0, 1);
    send_page(1, OpCheck, KindBitmap, 32'hFFFF_FFFF, 1, STORE_MATCH, 255, 1);
    // clamp both marker-valued CRCs
    send_page(1, OpCompute, KindNormal, seed_for_crc(MarkNormal), 1, STORE_RANDOM, 0, 1);
    send_page(1, OpCheck, KindBitmap, seed_for_crc(MarkBitmap), 1, STORE_MATCH, 0, 1);
    send_page(2, OpCheck, KindNormal, $urandom, 1, STORE_MARK_NORMAL, -1, 1);
    send_page(2, OpCheck, KindNormal, $urandom, 1, STORE_MARK_BITMAP, -1, 1);
    send_page(2, OpCheck, KindBitmap, $urandom, 1, STORE_MARK_BITMAP, -1, 1);
    send_page(2, OpCheck, KindBitmap, $urandom, 1, STORE_MARK_NORMAL, -1, 1);
    send_page(3, OpCheck, KindBitmap, $urandom, 1, STORE_ZERO, 0, 1);
    send_page(3, OpCheck, KindNormal, $urandom, 1, STORE_ZERO, 0, 1);
    send_page(3, OpCheck, KindBitmap, $urandom, 1, STORE_ZERO, 255, 1);
    send_page(2, OpCheck, KindNormal, $urandom, 1, STORE_NEAR, -1, 1);
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 75; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 75; rx_hold_req = 1'b1; end
        default: begin tx_idle_pct = 38; rx_stall_pct = 38; end
      endcase
      target = items_sent + PhaseItems;
      while (items_sent < target) random_page();
      drain_results();
    end

    if (sb.errors == 0) begin
      $display("page_crc_seal_and_check_unit verification clean");
    end else begin
      $display("page_crc_seal_and_check_unit verification failed");
    end
    $finish;
  end

endmodule

/* page_crc_seal_and_check_unit.f */
hw/rtl/pcrc_pkg.sv
hw/rtl/pcrc_engine.sv
hw/rtl/page_crc_seal_and_check_unit.sv
sim/tb_page_crc_seal_and_check_unit.sv
